### design/wiper_and_turn_signal_controller_top_macros.svh
// assertion macros for the wiper and turn signal controller checker
// used by wtsc_checker.sv, no other dependencies
`ifndef WIPER_AND_TURN_SIGNAL_CONTROLLER_TOP_MACROS_SVH
`define WIPER_AND_TURN_SIGNAL_CONTROLLER_TOP_MACROS_SVH

// implication checked from the same edge
`define WTSC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication checked at the following edge
`define WTSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/wtsc_pkg.sv
// shared types and constants of the wiper and turn signal controller
// no dependencies
`default_nettype none

package wtsc_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_LOW_THRESHOLD     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THRESHOLD    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_PERIOD_MS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_ON_MS       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNAL_TIMEOUT_MS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REST_PULSE        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_PULSE       = 3'd6;

    localparam logic [2:0] MODE_DEFAULT = 3'd0;
    localparam logic [2:0] MODE_WIPE    = 3'd1;
    localparam logic [2:0] MODE_SPEED   = 3'd2;
    localparam logic [2:0] MODE_UPLEFT  = 3'd3;
    localparam logic [2:0] MODE_UPRIGHT = 3'd4;
    localparam logic [2:0] MODE_RIGHT   = 3'd5;
    localparam logic [2:0] MODE_LEFT    = 3'd6;
    localparam logic [2:0] MODE_HAZARD  = 3'd7;

    localparam logic [9:0] WIPE_ONCE_HALF = 10'd800;
    localparam logic [9:0] GEAR1_HALF     = 10'd750;
    localparam logic [9:0] GEAR2_HALF     = 10'd550;
    localparam logic [9:0] GEAR3_HALF     = 10'd350;

    localparam logic [15:0] WIPE_MSG_MS     = 16'd2500;
    localparam logic [15:0] WASH_MSG_MS     = 16'd1000;
    localparam logic [15:0] HAZ_RETURN_MS   = 16'd1000;
    localparam logic [15:0] SPEED_RETURN_MS = 16'd2000;

    localparam logic ACT_TICK   = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    typedef enum logic [1:0] {
        SIG_OFF    = 2'd0,
        SIG_RIGHT  = 2'd1,
        SIG_LEFT   = 2'd2,
        SIG_HAZARD = 2'd3
    } t_sig;

    typedef struct packed {
        logic [11:0] low_threshold;
        logic [11:0] high_threshold;
        logic [15:0] blink_period_ms;
        logic [15:0] blink_on_ms;
        logic [15:0] signal_timeout_ms;
        logic [15:0] rest_pulse;
        logic [15:0] sweep_pulse;
    } t_cfg;

    typedef struct packed {
        logic        action;
        logic [11:0] joystick_x;
        logic [11:0] joystick_y;
    } t_in_word;

    typedef struct packed {
        logic [15:0] servo_pulse;
        logic        left_lamp;
        logic        right_lamp;
        logic [2:0]  display_mode;
        logic [1:0]  wiper_gear;
    } t_out_word;

endpackage

`default_nettype wire

### design/wtsc_cfg.sv
// configuration registers of the wiper and turn signal controller
// depends on wtsc_pkg
`default_nettype none

module wtsc_cfg (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [wtsc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [wtsc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output wtsc_pkg::t_cfg                           o_cfg
);

    wtsc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.low_threshold     <= 12'd1000;
            r_cfg.high_threshold    <= 12'd3500;
            r_cfg.blink_period_ms   <= 16'd1000;
            r_cfg.blink_on_ms       <= 16'd500;
            r_cfg.signal_timeout_ms <= 16'd5000;
            r_cfg.rest_pulse        <= 16'd450;
            r_cfg.sweep_pulse       <= 16'd2500;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                wtsc_pkg::CFG_LOW_THRESHOLD:     r_cfg.low_threshold     <= i_cfg_data[11:0];
                wtsc_pkg::CFG_HIGH_THRESHOLD:    r_cfg.high_threshold    <= i_cfg_data[11:0];
                wtsc_pkg::CFG_BLINK_PERIOD_MS:   r_cfg.blink_period_ms   <= i_cfg_data;
                wtsc_pkg::CFG_BLINK_ON_MS:       r_cfg.blink_on_ms       <= i_cfg_data;
                wtsc_pkg::CFG_SIGNAL_TIMEOUT_MS: r_cfg.signal_timeout_ms <= i_cfg_data;
                wtsc_pkg::CFG_REST_PULSE:        r_cfg.rest_pulse        <= i_cfg_data;
                wtsc_pkg::CFG_SWEEP_PULSE:       r_cfg.sweep_pulse       <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### design/wtsc_core.sv
// controller state and its one-step update for a tick or a joystick sample
// depends on wtsc_pkg
`default_nettype none

module wtsc_core (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_step,
    input  wire wtsc_pkg::t_in_word    i_word,
    input  wire wtsc_pkg::t_cfg        i_cfg,
    output wtsc_pkg::t_out_word        o_result
);

    typedef struct packed {
        logic [15:0]   wiper_elapsed;
        logic [15:0]   event_elapsed;
        logic [15:0]   blink_phase;
        logic [9:0]    half_period;
        logic [1:0]    gear;
        logic          swept;
        logic [2:0]    display;
        logic [2:0]    saved;
        wtsc_pkg::t_sig sig;
        logic          hazard_on;
    } t_state;

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    t_state r_st;
    t_state n_st;

    logic [16:0]     phase_inc;
    logic [15:0]     lamp_phase;
    wtsc_pkg::t_sig  lamp_sig;
    logic            lamp_on;
    logic            xl, xh, xm, yl, yh, ym;

    always_comb begin
        xl = i_word.joystick_x < i_cfg.low_threshold;
        xh = i_word.joystick_x > i_cfg.high_threshold;
        xm = !xl && !xh;
        yl = i_word.joystick_y < i_cfg.low_threshold;
        yh = i_word.joystick_y > i_cfg.high_threshold;
        ym = !yl && !yh;
    end

    always_comb begin
        n_st       = r_st;
        phase_inc  = {1'b0, r_st.blink_phase} + 17'd1;
        lamp_phase = '0;
        lamp_sig   = wtsc_pkg::SIG_OFF;

        if (i_word.action == wtsc_pkg::ACT_TICK) begin
            n_st.wiper_elapsed = sat_inc(r_st.wiper_elapsed);
            n_st.event_elapsed = sat_inc(r_st.event_elapsed);
            n_st.blink_phase   = (phase_inc >= {1'b0, i_cfg.blink_period_ms}) ?
                                 16'd0 : phase_inc[15:0];

            if (r_st.half_period != 10'd0) begin
                if (n_st.wiper_elapsed <= {6'd0, r_st.half_period}) begin
                    n_st.swept = 1'b0;
                end
                if (n_st.wiper_elapsed >= {6'd0, r_st.half_period}) begin
                    n_st.swept = 1'b1;
                end
                if (n_st.wiper_elapsed >= {5'd0, r_st.half_period, 1'b0}) begin
                    n_st.wiper_elapsed = '0;
                    if (r_st.half_period == wtsc_pkg::WIPE_ONCE_HALF) begin
                        n_st.swept       = 1'b0;
                        n_st.half_period = '0;
                    end
                end
            end

            lamp_phase = n_st.blink_phase;
            lamp_sig   = r_st.sig;

            if ((r_st.sig inside {wtsc_pkg::SIG_LEFT, wtsc_pkg::SIG_RIGHT}) &&
                n_st.event_elapsed >= i_cfg.signal_timeout_ms) begin
                n_st.sig = wtsc_pkg::SIG_OFF;
            end

            case (r_st.display)
                wtsc_pkg::MODE_WIPE: begin
                    if (n_st.event_elapsed >= wtsc_pkg::WIPE_MSG_MS) begin
                        n_st.display = r_st.saved;
                    end
                end
                wtsc_pkg::MODE_SPEED: begin
                    if (r_st.hazard_on && n_st.event_elapsed >= wtsc_pkg::HAZ_RETURN_MS) begin
                        n_st.display       = wtsc_pkg::MODE_HAZARD;
                        n_st.event_elapsed = '0;
                        n_st.blink_phase   = '0;
                    end
                end
                wtsc_pkg::MODE_UPLEFT, wtsc_pkg::MODE_UPRIGHT: begin
                    if (n_st.event_elapsed >= wtsc_pkg::WASH_MSG_MS) begin
                        n_st.display = r_st.saved;
                    end
                end
                wtsc_pkg::MODE_RIGHT, wtsc_pkg::MODE_LEFT: begin
                    if (n_st.event_elapsed >= i_cfg.signal_timeout_ms) begin
                        n_st.display = r_st.saved;
                    end
                end
                wtsc_pkg::MODE_HAZARD: begin
                    if (r_st.gear != 2'd0 &&
                        n_st.event_elapsed >= wtsc_pkg::SPEED_RETURN_MS) begin
                        n_st.display       = wtsc_pkg::MODE_SPEED;
                        n_st.event_elapsed = '0;
                        n_st.blink_phase   = '0;
                    end
                end
                default: begin
                end
            endcase
        end else begin
            if (xm && ym) begin
                // centre: no change
            end else if ((xl || xh) && ym) begin
                if (r_st.display == wtsc_pkg::MODE_SPEED) begin
                    n_st.saved = wtsc_pkg::MODE_SPEED;
                end
                n_st.display       = xl ? wtsc_pkg::MODE_RIGHT : wtsc_pkg::MODE_LEFT;
                n_st.sig           = xl ? wtsc_pkg::SIG_RIGHT : wtsc_pkg::SIG_LEFT;
                n_st.event_elapsed = '0;
                n_st.blink_phase   = '0;
                n_st.hazard_on     = 1'b0;
            end else if (xm && yl) begin
                n_st.gear          = r_st.gear + 2'd1;
                n_st.display       = wtsc_pkg::MODE_SPEED;
                n_st.event_elapsed = '0;
                n_st.blink_phase   = '0;
                case (n_st.gear)
                    2'd1: n_st.half_period = wtsc_pkg::GEAR1_HALF;
                    2'd2: n_st.half_period = wtsc_pkg::GEAR2_HALF;
                    2'd3: n_st.half_period = wtsc_pkg::GEAR3_HALF;
                    default: begin
                        n_st.half_period = '0;
                        n_st.swept       = 1'b0;
                    end
                endcase
            end else if (xm && yh) begin
                n_st.half_period   = wtsc_pkg::WIPE_ONCE_HALF;
                n_st.gear          = '0;
                n_st.display       = wtsc_pkg::MODE_WIPE;
                n_st.event_elapsed = '0;
                n_st.blink_phase   = '0;
                n_st.wiper_elapsed = '0;
            end else if ((xl || xh) && yh) begin
                if (r_st.display == wtsc_pkg::MODE_SPEED) begin
                    n_st.saved = wtsc_pkg::MODE_SPEED;
                end
                n_st.display       = xl ? wtsc_pkg::MODE_UPRIGHT : wtsc_pkg::MODE_UPLEFT;
                n_st.event_elapsed = '0;
                n_st.blink_phase   = '0;
            end else if (xh && yl) begin
                if (!r_st.hazard_on) begin
                    n_st.display       = wtsc_pkg::MODE_HAZARD;
                    n_st.sig           = wtsc_pkg::SIG_HAZARD;
                    n_st.event_elapsed = '0;
                    n_st.blink_phase   = '0;
                    n_st.hazard_on     = 1'b1;
                end else begin
                    n_st.display   = (r_st.gear != 2'd0) ? wtsc_pkg::MODE_SPEED :
                                                           wtsc_pkg::MODE_DEFAULT;
                    n_st.sig       = wtsc_pkg::SIG_OFF;
                    n_st.hazard_on = 1'b0;
                end
            end else begin
                n_st.display     = wtsc_pkg::MODE_DEFAULT;
                n_st.gear        = '0;
                n_st.half_period = '0;
                n_st.swept       = 1'b0;
                n_st.saved       = wtsc_pkg::MODE_DEFAULT;
                n_st.hazard_on   = 1'b0;
                n_st.sig         = wtsc_pkg::SIG_OFF;
            end
            lamp_phase = n_st.blink_phase;
            lamp_sig   = n_st.sig;
        end
    end

    always_comb begin
        lamp_on                = lamp_phase <= i_cfg.blink_on_ms;
        o_result.servo_pulse   = n_st.swept ? i_cfg.sweep_pulse : i_cfg.rest_pulse;
        o_result.left_lamp     = lamp_on && (lamp_sig inside {wtsc_pkg::SIG_LEFT,
                                                               wtsc_pkg::SIG_HAZARD});
        o_result.right_lamp    = lamp_on && (lamp_sig inside {wtsc_pkg::SIG_RIGHT,
                                                               wtsc_pkg::SIG_HAZARD});
        o_result.display_mode  = n_st.display;
        o_result.wiper_gear    = n_st.gear;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (i_step) begin
            r_st <= n_st;
        end
    end

endmodule

`default_nettype wire

### design/wiper_and_turn_signal_controller_top.sv
// wiper and turn signal controller, top level with input and result registers
// depends on wtsc_pkg, wtsc_cfg and wtsc_core
//
// usage
//   input word: action (0 millisecond tick, 1 joystick sample) and two 12 bit
//   axis samples, accepted when i_in_valid is high and o_in_stall is low
//   result word: servo pulse, two lamps, display mode and wiper gear, one per
//   input word, taken when o_out_valid is high and i_out_stall is low
//   configuration: i_cfg_we writes i_cfg_data to register i_cfg_index; the user
//   writes only while no word is in flight, which the block does not enforce
//   order: an accepted word is held in the input register, then the state update
//   writes its result into the result register, which raises o_out_valid
//   throughput: one word per cycle while the result side does not stall; the state
//   update is one short pass between the input register and the result register
//   stall: while the result is held, the input register keeps one more word,
//   and o_in_stall rises only when both are occupied
//   reset: synchronous, clears the controller state, both valid flags and
//   restores the configuration defaults
`default_nettype none

module wiper_and_turn_signal_controller_top (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output      logic                               o_in_stall,
    input  wire wtsc_pkg::t_in_word                 i_in_word,
    output      logic                               o_out_valid,
    input  wire logic                               i_out_stall,
    output wtsc_pkg::t_out_word                     o_out_word,
    input  wire logic                               i_cfg_we,
    input  wire logic [wtsc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [wtsc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    wtsc_pkg::t_cfg      cfg;
    wtsc_pkg::t_out_word result;

    logic                r_in_valid;
    wtsc_pkg::t_in_word  r_in_word;
    logic                r_out_valid;
    wtsc_pkg::t_out_word r_out_word;

    logic                advance;
    logic                in_accept;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    wtsc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    wtsc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_word   (r_in_word),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_word <= i_in_word;
        end
        if (advance) begin
            r_out_word <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

`default_nettype wire

### design/wtsc_checker.sv
// port-level checks of the wiper and turn signal controller, bound to the top
// depends on wtsc_pkg and wiper_and_turn_signal_controller_top_macros.svh
`default_nettype none

`include "wiper_and_turn_signal_controller_top_macros.svh"

module wtsc_checker (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             i_in_valid,
    input wire logic                             o_in_stall,
    input wire wtsc_pkg::t_in_word               i_in_word,
    input wire logic                             o_out_valid,
    input wire logic                             i_out_stall,
    input wire wtsc_pkg::t_out_word              o_out_word,
    input wire logic                             i_cfg_we,
    input wire logic [wtsc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input wire logic [wtsc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic in_accept;

    assign in_accept = i_in_valid && !o_in_stall;

    // held result word stays put
    `WTSC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_out_word), "result word changed while stalled")

    // held input word stays put
    `WTSC_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_in_valid && o_in_stall,
        i_in_valid && $stable(i_in_word), "input word changed while stalled")

    // no result right after reset
    `WTSC_ASSERT_SAME(a_reset_empty, i_clk, i_rst_n, $past(!i_rst_n),
        !o_out_valid, "result valid right after reset")

    // an accepted word leads to a valid result word
    `WTSC_ASSERT_SAME(a_accept_result, i_clk, i_rst_n, in_accept,
        ##2 o_out_valid, "accepted word gave no result in time")

    // register writes only while idle, with known index and data
    `WTSC_ASSERT_SAME(a_cfg_idle, i_clk, i_rst_n, i_cfg_we,
        !o_out_valid && !$isunknown(i_cfg_index) && !$isunknown(i_cfg_data),
        "register write while busy or with unknown value")

endmodule

bind wiper_and_turn_signal_controller_top wtsc_checker u_wtsc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_index (i_cfg_index),
    .i_cfg_data  (i_cfg_data)
);

`default_nettype wire

### bench/wiper_and_turn_signal_controller_top_test.sv
// self-checking testbench for wiper_and_turn_signal_controller_top
// predicts every result word from its own model of the controller and compares field by field
// depends on wtsc_pkg and the controller rtl only
`timescale 1ns / 1ps

module wiper_and_turn_signal_controller_top_test;

    import wtsc_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 3'd7;

    typedef enum logic [1:0] {
        AXIS_LOW,
        AXIS_MID,
        AXIS_HIGH
    } t_axis;

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_in_word              i_in_word = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_word             o_out_word;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // controller model state
    t_cfg        cfg;
    logic [15:0] wiper_ms;
    logic [15:0] event_ms;
    logic [15:0] blink_ms;
    logic [9:0]  half_period;
    logic [1:0]  gear_q;
    logic        swept;
    logic [2:0]  disp;
    logic [2:0]  saved_disp;
    t_sig        sig;
    logic        hazard;

    t_out_word pending_outputs[$];

    int  cycle_count = 0;
    int  words_sent = 0;
    int  sticks_sent = 0;
    int  results_checked = 0;
    int  reg_writes = 0;
    int  mismatch_count = 0;
    int  hold_cycles = 0;
    bit  send_idle_on = 1'b0;
    bit  stall_on = 1'b0;

    wiper_and_turn_signal_controller_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic void reset_controller();
        cfg.low_threshold     = 12'd1000;
        cfg.high_threshold    = 12'd3500;
        cfg.blink_period_ms   = 16'd1000;
        cfg.blink_on_ms       = 16'd500;
        cfg.signal_timeout_ms = 16'd5000;
        cfg.rest_pulse        = 16'd450;
        cfg.sweep_pulse       = 16'd2500;
        wiper_ms    = '0;
        event_ms    = '0;
        blink_ms    = '0;
        half_period = '0;
        gear_q      = '0;
        swept       = 1'b0;
        disp        = MODE_DEFAULT;
        saved_disp  = MODE_DEFAULT;
        sig         = SIG_OFF;
        hazard      = 1'b0;
    endfunction

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic void restart_event_timer();
        event_ms = '0;
        blink_ms = '0;
    endfunction

    function automatic void hold_speed_mode();
        if (disp == MODE_SPEED) begin
            saved_disp = MODE_SPEED;
        end
    endfunction

    function automatic void start_signal(input logic [2:0] mode, input t_sig side);
        hold_speed_mode();
        disp = mode;
        sig = side;
        restart_event_timer();
        hazard = 1'b0;
    endfunction

    function automatic void show_lamps(output logic left, output logic right);
        logic lit;
        lit = blink_ms <= cfg.blink_on_ms;
        left = (sig == SIG_LEFT || sig == SIG_HAZARD) && lit;
        right = (sig == SIG_RIGHT || sig == SIG_HAZARD) && lit;
    endfunction

    function automatic void apply_stick(input logic [11:0] x, input logic [11:0] y);
        logic xl, xh, xm, yl, yh, ym;
        xl = x < cfg.low_threshold;
        xh = x > cfg.high_threshold;
        xm = !xl && !xh;
        yl = y < cfg.low_threshold;
        yh = y > cfg.high_threshold;
        ym = !yl && !yh;
        if (xm && ym) begin
        end else if (xl && ym) begin
            start_signal(MODE_RIGHT, SIG_RIGHT);
        end else if (xh && ym) begin
            start_signal(MODE_LEFT, SIG_LEFT);
        end else if (xm && yl) begin
            gear_q = gear_q + 2'd1;
            disp = MODE_SPEED;
            case (gear_q)
                2'd1: half_period = GEAR1_HALF;
                2'd2: half_period = GEAR2_HALF;
                2'd3: half_period = GEAR3_HALF;
                default: begin
                    half_period = '0;
                    swept = 1'b0;
                end
            endcase
            restart_event_timer();
        end else if (xm && yh) begin
            half_period = WIPE_ONCE_HALF;
            gear_q = '0;
            disp = MODE_WIPE;
            restart_event_timer();
            wiper_ms = '0;
        end else if (xl && yh) begin
            hold_speed_mode();
            disp = MODE_UPRIGHT;
            restart_event_timer();
        end else if (xh && yh) begin
            hold_speed_mode();
            disp = MODE_UPLEFT;
            restart_event_timer();
        end else if (xh && yl) begin
            if (!hazard) begin
                disp = MODE_HAZARD;
                sig = SIG_HAZARD;
                restart_event_timer();
                hazard = 1'b1;
            end else begin
                disp = (gear_q != 2'd0) ? MODE_SPEED : MODE_DEFAULT;
                sig = SIG_OFF;
                hazard = 1'b0;
            end
        end else begin
            disp = MODE_DEFAULT;
            gear_q = '0;
            half_period = '0;
            swept = 1'b0;
            saved_disp = MODE_DEFAULT;
            hazard = 1'b0;
            sig = SIG_OFF;
        end
    endfunction

    // updates the model for one accepted word and queues the result it must produce
    function automatic void advance_controller(input t_in_word w);
        t_out_word res;
        logic      left, right;
        int        nxt;
        int        half;
        if (w.action == ACT_TICK) begin
            wiper_ms = sat_inc(wiper_ms);
            event_ms = sat_inc(event_ms);
            nxt = int'(blink_ms) + 1;
            blink_ms = (nxt >= int'(cfg.blink_period_ms)) ? 16'd0 : nxt[15:0];
            half = int'(half_period);
            if (half != 0) begin
                if (int'(wiper_ms) <= half) swept = 1'b0;
                if (int'(wiper_ms) >= half) swept = 1'b1;
                if (int'(wiper_ms) >= 2 * half) begin
                    wiper_ms = '0;
                    if (half_period == WIPE_ONCE_HALF) begin
                        swept = 1'b0;
                        half_period = '0;
                    end
                end
            end
            show_lamps(left, right);
            if ((sig == SIG_LEFT || sig == SIG_RIGHT) && event_ms >= cfg.signal_timeout_ms) begin
                sig = SIG_OFF;
            end
            case (disp)
                MODE_WIPE: begin
                    if (event_ms >= WIPE_MSG_MS) disp = saved_disp;
                end
                MODE_SPEED: begin
                    if (hazard && event_ms >= HAZ_RETURN_MS) begin
                        disp = MODE_HAZARD;
                        restart_event_timer();
                    end
                end
                MODE_UPLEFT, MODE_UPRIGHT: begin
                    if (event_ms >= WASH_MSG_MS) disp = saved_disp;
                end
                MODE_RIGHT, MODE_LEFT: begin
                    if (event_ms >= cfg.signal_timeout_ms) disp = saved_disp;
                end
                MODE_HAZARD: begin
                    if (gear_q != 2'd0 && event_ms >= SPEED_RETURN_MS) begin
                        disp = MODE_SPEED;
                        restart_event_timer();
                    end
                end
                default: begin
                end
            endcase
        end else begin
            apply_stick(w.joystick_x, w.joystick_y);
            show_lamps(left, right);
        end
        res.servo_pulse  = swept ? cfg.sweep_pulse : cfg.rest_pulse;
        res.left_lamp    = left;
        res.right_lamp   = right;
        res.display_mode = disp;
        res.wiper_gear   = gear_q;
        pending_outputs.push_back(res);
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_outputs.size() == 0) begin
                $error("result word arrived with nothing expected");
                mismatch_count++;
            end else begin
                want = pending_outputs.pop_front();
                results_checked++;
                if (o_out_word.servo_pulse !== want.servo_pulse) begin
                    $error("servo_pulse expected %0d actual %0d",
                           want.servo_pulse, o_out_word.servo_pulse);
                    mismatch_count++;
                end
                if (o_out_word.left_lamp !== want.left_lamp) begin
                    $error("left_lamp expected %0d actual %0d",
                           want.left_lamp, o_out_word.left_lamp);
                    mismatch_count++;
                end
                if (o_out_word.right_lamp !== want.right_lamp) begin
                    $error("right_lamp expected %0d actual %0d",
                           want.right_lamp, o_out_word.right_lamp);
                    mismatch_count++;
                end
                if (o_out_word.display_mode !== want.display_mode) begin
                    $error("display_mode expected %0d actual %0d",
                           want.display_mode, o_out_word.display_mode);
                    mismatch_count++;
                end
                if (o_out_word.wiper_gear !== want.wiper_gear) begin
                    $error("wiper_gear expected %0d actual %0d",
                           want.wiper_gear, o_out_word.wiper_gear);
                    mismatch_count++;
                end
            end
        end
    end

    // result side stall, random or one long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_cycles != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold_cycles) @(negedge i_clk);
                hold_cycles = 0;
                i_out_stall <= 1'b0;
            end else if (stall_on && $urandom_range(0, 2) == 0) begin
                i_out_stall <= 1'b1;
                repeat (gap_len() + 1) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $error("timed out after %0d cycles", cycle_count);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic send_word(input t_in_word w);
        int gap;
        gap = send_idle_on ? gap_len() : 0;
        if (gap != 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_word <= w;
        do @(posedge i_clk); while (o_in_stall);
        advance_controller(w);
        words_sent++;
        if (w.action == ACT_SAMPLE) sticks_sent++;
    endtask

    task automatic send_stick(input logic [11:0] x, input logic [11:0] y);
        t_in_word w;
        w.action = ACT_SAMPLE;
        w.joystick_x = x;
        w.joystick_y = y;
        send_word(w);
    endtask

    task automatic tick_run(input int count);
        t_in_word w;
        repeat (count) begin
            w.action = ACT_TICK;
            w.joystick_x = 12'($urandom);
            w.joystick_y = 12'($urandom);
            send_word(w);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_LOW_THRESHOLD:     cfg.low_threshold = data[11:0];
            CFG_HIGH_THRESHOLD:    cfg.high_threshold = data[11:0];
            CFG_BLINK_PERIOD_MS:   cfg.blink_period_ms = data;
            CFG_BLINK_ON_MS:       cfg.blink_on_ms = data;
            CFG_SIGNAL_TIMEOUT_MS: cfg.signal_timeout_ms = data;
            CFG_REST_PULSE:        cfg.rest_pulse = data;
            CFG_SWEEP_PULSE:       cfg.sweep_pulse = data;
            default: begin
            end
        endcase
        reg_writes++;
    endtask

    // thresholds go out with random upper bits, which the block must drop
    task automatic load_settings(input logic [11:0] lo, input logic [11:0] hi,
                                 input logic [15:0] period, input logic [15:0] on_ms,
                                 input logic [15:0] timeout, input logic [15:0] rest,
                                 input logic [15:0] sweep);
        logic [3:0] junk_lo, junk_hi;
        junk_lo = 4'($urandom);
        junk_hi = 4'($urandom);
        drain();
        write_reg(CFG_LOW_THRESHOLD, {junk_lo, lo});
        write_reg(CFG_HIGH_THRESHOLD, {junk_hi, hi});
        write_reg(CFG_BLINK_PERIOD_MS, period);
        write_reg(CFG_BLINK_ON_MS, on_ms);
        write_reg(CFG_SIGNAL_TIMEOUT_MS, timeout);
        write_reg(CFG_REST_PULSE, rest);
        write_reg(CFG_SWEEP_PULSE, sweep);
    endtask

    function automatic logic [11:0] axis_in(input t_axis side);
        logic [11:0] v;
        v = 12'($urandom);
        case (side)
            AXIS_LOW: begin
                if (cfg.low_threshold != 12'd0)
                    v = 12'($urandom_range(0, cfg.low_threshold - 1));
            end
            AXIS_HIGH: begin
                if (cfg.high_threshold != 12'hFFF)
                    v = 12'($urandom_range(cfg.high_threshold + 1, 4095));
            end
            default: begin
                if (cfg.low_threshold <= cfg.high_threshold)
                    v = 12'($urandom_range(cfg.low_threshold, cfg.high_threshold));
            end
        endcase
        return v;
    endfunction

    // joystick word aimed at one zone, reset zone kept rare so state builds up
    function automatic t_in_word random_stick();
        t_in_word w;
        t_axis    xs, ys;
        int       pick;
        pick = $urandom_range(0, 99);
        xs = AXIS_MID;
        ys = AXIS_MID;
        if (pick < 8) begin
        end else if (pick < 20) begin
            xs = AXIS_LOW;
        end else if (pick < 32) begin
            xs = AXIS_HIGH;
        end else if (pick < 50) begin
            ys = AXIS_LOW;
        end else if (pick < 60) begin
            ys = AXIS_HIGH;
        end else if (pick < 68) begin
            xs = AXIS_LOW;
            ys = AXIS_HIGH;
        end else if (pick < 76) begin
            xs = AXIS_HIGH;
            ys = AXIS_HIGH;
        end else if (pick < 86) begin
            xs = AXIS_HIGH;
            ys = AXIS_LOW;
        end else if (pick < 90) begin
            xs = AXIS_LOW;
            ys = AXIS_LOW;
        end
        w.action = ACT_SAMPLE;
        w.joystick_x = axis_in(xs);
        w.joystick_y = axis_in(ys);
        if (pick >= 90) begin
            w.joystick_x = 12'($urandom);
            w.joystick_y = 12'($urandom);
        end
        return w;
    endfunction

    task automatic random_words(input int count);
        int done_words, pick, burst;
        done_words = 0;
        while (done_words < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 28) begin
                send_word(random_stick());
                done_words++;
            end else if (pick < 30) begin
                burst = $urandom_range(10, 150);
                tick_run(burst);
                done_words += burst;
            end else begin
                tick_run(1);
                done_words++;
            end
        end
    endtask

    task automatic test_zone_map();
        send_idle_on = 1'b1;
        stall_on = 1'b1;
        send_stick(12'd2000, 12'd2000);
        send_stick(12'd999, 12'd2000);
        send_stick(12'd1000, 12'd2000);
        send_stick(12'd3500, 12'd2000);
        send_stick(12'd3501, 12'd2000);
        send_stick(12'd2000, 12'd0);
        send_stick(12'd2000, 12'd0);
        send_stick(12'd2000, 12'd0);
        send_stick(12'd2000, 12'd0);
        send_stick(12'd2000, 12'd4095);
        send_stick(12'd0, 12'd4095);
        send_stick(12'd4095, 12'd4095);
        send_stick(12'd4095, 12'd0);
        tick_run(1);
        send_stick(12'd4095, 12'd0);
        send_stick(12'd0, 12'd0);
    endtask

    // low above high, so a middle value counts as both sides
    task automatic test_crossed_thresholds();
        load_settings(12'd3000, 12'd1000, 16'd1000, 16'd500, 16'd5000, 16'd450, 16'd2500);
        send_stick(12'd2000, 12'd2000);
        send_stick(12'd500, 12'd2000);
        send_stick(12'd3500, 12'd2000);
        send_stick(12'd2000, 12'd500);
        send_stick(12'd2000, 12'd3500);
        send_stick(12'd3500, 12'd500);
        send_stick(12'd500, 12'd500);
    endtask

    task automatic test_zero_settings();
        load_settings(12'd1000, 12'd3500, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF);
        write_reg(CFG_UNUSED_INDEX, 16'($urandom));
        send_stick(12'd4095, 12'd0);
        tick_run(3);
        send_stick(12'd4095, 12'd0);
        send_stick(12'd4095, 12'd2000);
        tick_run(2);
    endtask

    // speed with hazard swaps to hazard, then washer message, short turn signals and a single wipe
    task automatic test_timeouts();
        send_idle_on = 1'b0;
        stall_on = 1'b0;
        load_settings(12'd1000, 12'd3500, 16'd1000, 16'd500, 16'd40, 16'd450, 16'd2500);
        send_stick(12'd0, 12'd0);
        send_stick(12'd2000, 12'd0);
        send_stick(12'd4095, 12'd0);
        send_stick(12'd2000, 12'd0);
        tick_run(1010);
        send_stick(12'd4095, 12'd4095);
        tick_run(20);
        send_stick(12'd4095, 12'd2000);
        tick_run(60);
        send_stick(12'd0, 12'd2000);
        tick_run(60);
        send_stick(12'd2000, 12'd4095);
        tick_run(100);
    endtask

    task automatic test_backpressure();
        drain();
        send_idle_on = 1'b0;
        stall_on = 1'b0;
        hold_cycles = 60;
        random_words(40);
        drain();
    endtask

    task automatic test_random_traffic();
        send_idle_on = 1'b1;
        stall_on = 1'b1;
        load_settings(12'd1000, 12'd3500, 16'd1000, 16'd500, 16'd5000, 16'd450, 16'd2500);
        random_words(120);
        load_settings(12'($urandom_range(500, 1500)), 12'($urandom_range(2500, 3600)),
                      16'($urandom_range(1, 16)), 16'($urandom_range(0, 16)),
                      16'($urandom_range(1, 60)), 16'($urandom), 16'($urandom));
        random_words(120);
        load_settings(12'd0, 12'd4095, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
        random_words(40);
        load_settings(12'd4095, 12'd0, 16'($urandom_range(1, 16)), 16'($urandom_range(0, 16)),
                      16'($urandom_range(1, 60)), 16'($urandom), 16'($urandom));
        random_words(110);
        send_idle_on = 1'b0;
        stall_on = 1'b0;
        load_settings(12'($urandom_range(200, 1800)), 12'($urandom_range(2200, 3900)),
                      16'd1, 16'd0, 16'd1, 16'($urandom), 16'($urandom));
        random_words(110);
    endtask

    initial begin
        reset_controller();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_zone_map();
        test_crossed_thresholds();
        test_zero_settings();
        test_timeouts();
        test_backpressure();
        test_random_traffic();

        drain();
        repeat (8) @(posedge i_clk);
        $display("run covered %0d words (%0d joystick samples) over %0d register writes,",
                 words_sent, sticks_sent, reg_writes);
        $display("%0d result words checked, %0d field mismatches",
                 results_checked, mismatch_count);
        if (mismatch_count == 0 && pending_outputs.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### files.f
+incdir+design
design/wtsc_pkg.sv
design/wtsc_cfg.sv
design/wtsc_core.sv
design/wiper_and_turn_signal_controller_top.sv
design/wtsc_checker.sv
bench/wiper_and_turn_signal_controller_top_test.sv
